// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, ignored while in reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/jeti_pkg.sv -----
// ----------------------------------------------------------------------------
// jeti_pkg
// Types, constants and control structs for the escape-time iterator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jeti_pkg;

  localparam int IN_W            = 32;
  localparam int DP_W            = 40;
  localparam int DP_FRAC         = 32;
  localparam int HALF_W          = DP_W / 2;
  localparam int CFG_W           = 16;
  localparam int CNT_OUT_W       = 16;
  localparam int FRAC_BITS_DEF   = 29;
  localparam int COUNT_WIDTH_DEF = 16;

  typedef logic signed [IN_W-1:0] coord_t;
  typedef logic signed [DP_W-1:0] dp_t;

  localparam logic [CFG_W-1:0] MAX_ITER_RESET = 16'd256;

  localparam dp_t DP_MAX = 40'sh7F_FFFF_FFFF;
  localparam dp_t DP_MIN = 40'sh80_0000_0000;

  // 4.0 in the 32-fraction-bit format, one bit wider than a datapath word
  localparam logic [DP_W:0] FOUR_FX = 41'd4 << DP_FRAC;

  typedef enum logic [1:0] {
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_TEST,
    ST_CROSS,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    start_mul;
    mul_op_t mul_op;
    logic    save_rq;
    logic    save_iq;
    logic    update;
    logic    result_load;
    logic    result_esc;
  } jeti_cmd_t;

  typedef struct packed {
    logic load_sat;
    logic limit_zero;
    logic mul_done;
    logic esc_test;
    logic upd_sat;
    logic at_limit;
  } jeti_sts_t;

  typedef struct packed {
    logic sat;
    dp_t  val;
  } sat_res_t;

endpackage

`default_nettype wire

// ----- rtl/jeti_mul.sv -----
// ----------------------------------------------------------------------------
// jeti_mul
// Shared 40x40 signed multiplier: four 20x20 partial products, one a cycle,
// result floored to 32 fraction bits and saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeti_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire jeti_pkg::dp_t a,
  input  wire jeti_pkg::dp_t b,
  output logic               done,
  output jeti_pkg::dp_t      prod,
  output logic               sat
);
  import jeti_pkg::*;

  localparam logic [DP_W+7:0] MAG_LIM_POS = 48'h00_7F_FFFF_FFFF;
  localparam logic [DP_W+7:0] MAG_LIM_NEG = 48'h00_80_0000_0000;

  logic [DP_W-1:0]   ma;
  logic [DP_W-1:0]   mb;
  logic              neg;
  logic [2*DP_W-1:0] acc;
  logic [1:0]        phase;
  logic              busy;

  logic [HALF_W-1:0]   ah;
  logic [HALF_W-1:0]   bh;
  logic [2*HALF_W-1:0] pp;
  logic [2*DP_W-1:0]   term;

  always_comb begin
    ah = phase[1] ? ma[DP_W-1:HALF_W] : ma[HALF_W-1:0];
    bh = phase[0] ? mb[DP_W-1:HALF_W] : mb[HALF_W-1:0];
    pp = ah * bh;
    unique case (phase)
      2'd0:    term = (2*DP_W)'(pp);
      2'd3:    term = (2*DP_W)'(pp) << (2*HALF_W);
      default: term = (2*DP_W)'(pp) << HALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= busy && (phase == 2'd3);
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[DP_W-1] ? DP_W'(-a) : DP_W'(a);
      mb  <= b[DP_W-1] ? DP_W'(-b) : DP_W'(b);
      neg <= a[DP_W-1] ^ b[DP_W-1];
      acc <= '0;
    end else if (busy) begin
      acc <= acc + term;
    end
  end

  // floor to 32 fraction bits: magnitude rounds up when negative
  logic [DP_W+7:0] q;
  logic [DP_W+7:0] qn;
  logic [DP_W+7:0] qneg;
  logic            rem;

  always_comb begin
    q    = acc[2*DP_W-1:DP_FRAC];
    rem  = |acc[DP_FRAC-1:0];
    qn   = q + (DP_W+8)'(rem);
    qneg = (DP_W+8)'(0) - qn;
    if (neg) begin
      if (qn > MAG_LIM_NEG) begin
        sat  = 1'b1;
        prod = DP_MIN;
      end else begin
        sat  = 1'b0;
        prod = qneg[DP_W-1:0];
      end
    end else begin
      if (q > MAG_LIM_POS) begin
        sat  = 1'b1;
        prod = DP_MAX;
      end else begin
        sat  = 1'b0;
        prod = q[DP_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jeti_dp.sv -----
// ----------------------------------------------------------------------------
// jeti_dp
// Datapath: coordinate load, squares, escape test, z update, step counter,
// limit register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeti_dp #(
  parameter int FRAC_BITS   = jeti_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = jeti_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire jeti_pkg::jeti_cmd_t            cmd,
  output jeti_pkg::jeti_sts_t                 sts,
  input  wire logic                           cfg_wr_en,
  input  wire logic [jeti_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire jeti_pkg::coord_t               param_re,
  input  wire jeti_pkg::coord_t               param_im,
  input  wire jeti_pkg::coord_t               start_re,
  input  wire jeti_pkg::coord_t               start_im,
  output logic [jeti_pkg::CNT_OUT_W-1:0]      iter_count,
  output logic                                escaped
);
  import jeti_pkg::*;

  localparam int SH    = DP_FRAC + 1 - FRAC_BITS;
  localparam int LSH   = (SH > 0) ? SH : 0;
  localparam int RSH   = (SH < 0) ? -SH : 0;
  localparam int LIM_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [LIM_W-1:0] CNT_CAP = LIM_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic signed [63:0] DP_MAX_W = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] DP_MIN_W = 64'shFFFF_FF80_0000_0000;

  function automatic sat_res_t sat_dp(input logic signed [63:0] v);
    sat_res_t r;
    if (v > DP_MAX_W) begin
      r.sat = 1'b1;
      r.val = DP_MAX;
    end else if (v < DP_MIN_W) begin
      r.sat = 1'b1;
      r.val = DP_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[DP_W-1:0];
    end
    return r;
  endfunction

  // doubled and rescaled to 32 fraction bits; right shift floors
  function automatic sat_res_t load_coord(input coord_t v);
    logic signed [63:0] ext;
    ext = 64'(v);
    ext = (ext <<< LSH) >>> RSH;
    return sat_dp(ext);
  endfunction

  logic [CFG_W-1:0]       max_iter;
  dp_t                    cr;
  dp_t                    ci;
  dp_t                    zr;
  dp_t                    zi;
  dp_t                    rq;
  dp_t                    iq;
  logic                   sq_sat;
  logic                   load_sat;
  logic                   upd_sat;
  logic [COUNT_WIDTH-1:0] count;

  dp_t  mul_a;
  dp_t  mul_b;
  logic mul_done;
  dp_t  mul_prod;
  logic mul_sat;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_RR: begin
        mul_a = zr;
        mul_b = zr;
      end
      MUL_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zi;
        mul_b = zr;
      end
    endcase
  end

  jeti_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_mul),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod),
    .sat   (mul_sat)
  );

  sat_res_t ld_cr;
  sat_res_t ld_ci;
  sat_res_t ld_zr;
  sat_res_t ld_zi;
  sat_res_t twice_t;
  sat_res_t zi_new;
  sat_res_t zr_new;

  always_comb begin
    ld_cr   = load_coord(param_re);
    ld_ci   = load_coord(param_im);
    ld_zr   = load_coord(start_re);
    ld_zi   = load_coord(start_im);
    twice_t = sat_dp(64'(mul_prod) + 64'(mul_prod));
    zi_new  = sat_dp(64'(twice_t.val) + 64'(ci));
    zr_new  = sat_dp(64'(rq) - 64'(iq) + 64'(cr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RESET;
    end else if (cfg_wr_en) begin
      max_iter <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr       <= ld_cr.val;
      ci       <= ld_ci.val;
      zr       <= ld_zr.val;
      zi       <= ld_zi.val;
      load_sat <= ld_cr.sat | ld_ci.sat | ld_zr.sat | ld_zi.sat;
      count    <= '0;
    end else if (cmd.update) begin
      zr      <= zr_new.val;
      zi      <= zi_new.val;
      upd_sat <= mul_sat | twice_t.sat | zi_new.sat | zr_new.sat;
      count   <= count + 1'b1;
    end
    if (cmd.save_rq) begin
      rq     <= mul_prod;
      sq_sat <= mul_sat;
    end
    if (cmd.save_iq) begin
      iq     <= mul_prod;
      sq_sat <= sq_sat | mul_sat;
    end
  end

  logic [LIM_W-1:0] cfg_ext;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] cnt_ext;
  logic [DP_W:0]    sq_sum;

  always_comb begin
    cfg_ext = LIM_W'(max_iter);
    limit   = (cfg_ext < CNT_CAP) ? cfg_ext : CNT_CAP;
    cnt_ext = LIM_W'(count);
    // both squares are non-negative
    sq_sum  = (DP_W+1)'(unsigned'(rq)) + (DP_W+1)'(unsigned'(iq));

    sts.load_sat   = load_sat;
    sts.limit_zero = (limit == '0);
    sts.mul_done   = mul_done;
    sts.esc_test   = sq_sat | (sq_sum > FOUR_FX);
    sts.upd_sat    = upd_sat;
    sts.at_limit   = (cnt_ext == limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      iter_count <= cnt_ext[CNT_OUT_W-1:0];
      escaped    <= cmd.result_esc;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jeti_ctrl.sv -----
// ----------------------------------------------------------------------------
// jeti_ctrl
// Sequencer: drives the multiplier through the three products of a step and
// decides when a point is finished.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeti_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output jeti_pkg::jeti_cmd_t      cmd,
  input  wire jeti_pkg::jeti_sts_t sts
);
  import jeti_pkg::*;

  state_t state;
  state_t state_next;
  logic   esc;
  logic   esc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      esc       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      esc   <= esc_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    esc_next   = esc;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ENTRY;
      end
      ST_ENTRY: begin
        priority if (sts.limit_zero) begin
          esc_next   = 1'b0;
          state_next = ST_FINISH;
        end else if (sts.load_sat) begin
          esc_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SQ_RE;
        end
      end
      ST_SQ_RE: begin
        if (sts.mul_done) state_next = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        if (sts.mul_done) state_next = ST_TEST;
      end
      ST_TEST: begin
        if (sts.esc_test) begin
          esc_next   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (sts.mul_done) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        priority if (sts.upd_sat) begin
          esc_next   = 1'b1;
          state_next = ST_FINISH;
        end else if (sts.at_limit) begin
          esc_next   = 1'b0;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SQ_RE;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.mul_op     = MUL_RR;
    cmd.result_esc = esc;
    in_ready       = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_ENTRY: begin
        cmd.start_mul = !sts.limit_zero && !sts.load_sat;
      end
      ST_SQ_RE: begin
        cmd.save_rq   = sts.mul_done;
        cmd.start_mul = sts.mul_done;
        cmd.mul_op    = MUL_II;
      end
      ST_SQ_IM: begin
        cmd.save_iq = sts.mul_done;
      end
      ST_TEST: begin
        cmd.start_mul = !sts.esc_test;
        cmd.mul_op    = MUL_RI;
      end
      ST_CROSS: begin
        cmd.update = sts.mul_done;
        cmd.mul_op = MUL_RI;
      end
      ST_NEXT: begin
        cmd.start_mul = !sts.upd_sat && !sts.at_limit;
      end
      ST_FINISH: begin
        cmd.result_load = !out_valid || out_ready;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/julia_escape_time_iterator_top.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time_iterator_top
// Fixed-point escape-time iterator: z <- z^2 + c until |z|^2 > 4, saturation or limit.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  cfg      | cfg_wr_en (no wait)     | cfg_wr_data: max_iterations, 16 b
//  in       | in_valid / in_ready     | param_re, param_im, start_re, start_im
//  out      | out_valid / out_ready   | iter_count 16 b, escaped 1 b
//
//  One item in flight. Each iteration runs on the single shared multiplier
//  (three 40x40 products per step). An item ends when the limit is reached,
//  when a saturated update or the escape test fires, or at entry for a zero
//  limit or entry saturation. Reset is synchronous and sets the limit to 256.
//  The result waits in an output register; the next item is taken meanwhile,
//  and a stalled result holds the sequencer only at its final state.
//
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time_iterator_top #(
  parameter int FRAC_BITS   = jeti_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = jeti_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // limit register write
  input  wire logic                        cfg_wr_en,
  input  wire logic [jeti_pkg::CFG_W-1:0]  cfg_wr_data,
  // point in
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire jeti_pkg::coord_t            param_re,
  input  wire jeti_pkg::coord_t            param_im,
  input  wire jeti_pkg::coord_t            start_re,
  input  wire jeti_pkg::coord_t            start_im,
  // result out
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [jeti_pkg::CNT_OUT_W-1:0]   iter_count,
  output logic                             escaped
);
  import jeti_pkg::*;

  jeti_cmd_t cmd;
  jeti_sts_t sts;

  // sequencer: state machine only, talks to the datapath through cmd/sts
  jeti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: coordinates, shared multiplier, counter, limit, result register
  jeti_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .param_re    (param_re),
    .param_im    (param_im),
    .start_re    (start_re),
    .start_im    (start_im),
    .iter_count  (iter_count),
    .escaped     (escaped)
  );

endmodule

`default_nettype wire

// ----- rtl/jeti_chk.sv -----
// ----------------------------------------------------------------------------
// jeti_chk
// Port-level checks for the iterator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module jeti_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [jeti_pkg::CNT_OUT_W-1:0]    iter_count,
  input wire logic                              escaped
);

  // one item at a time: busy straight after taking an item
  `CHK_ASSERT(a_busy_after_accept, clk, rst,
    in_valid && in_ready |=> !in_ready,
    "ready after accept")

  // ready only drops because an item was taken
  `CHK_IMPLY(a_ready_drop, clk, rst, $fell(in_ready), $past(in_valid), "ready fell without item")

  // a result appears only at the end of work on an item
  `CHK_IMPLY(a_result_after_work, clk, rst,
    $rose(out_valid), $past(!in_ready),
    "result from idle")

  // stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(iter_count) && $stable(escaped),
    "result changed while stalled")

endmodule

bind julia_escape_time_iterator_top jeti_chk u_jeti_chk (.*);

`default_nettype wire
